@@ hw/rtl/brf_pkg.sv @@
// Shared types and codes for the byte ring FIFO.
`timescale 1ns / 1ps
`default_nettype none
package brf_pkg;

  localparam int unsigned CFG_W = 9;
  localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Result control handed from the pointer logic to the output stage
  typedef struct packed {
    logic    valid;
    logic    rd_ok;
    status_t status;
  } brf_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/brf_store.sv @@
// Byte store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module brf_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned PTR_W = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [PTR_W-1:0] waddr,
  input  wire logic [7:0]       wdata,
  input  wire logic             re,
  input  wire logic [PTR_W-1:0] raddr,
  output logic      [7:0]       rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/brf_ctrl.sv @@
// Pointer logic: fault check, full/empty decision, store access and result status.
`timescale 1ns / 1ps
`default_nettype none
module brf_ctrl import brf_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned PTR_W = 8,
  parameter int unsigned CAP_W = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             func,
  input  wire logic [CFG_W-1:0] capacity,
  output logic                  mem_we,
  output logic [PTR_W-1:0]      mem_waddr,
  output logic                  mem_re,
  output logic [PTR_W-1:0]      mem_raddr,
  output brf_res_t              res
);

  localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] ONE_C   = CAP_W'(1);

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  brf_res_t         res_r, res_nxt;

  logic [CAP_W-1:0] cap_raw, cap_eff;
  logic [CAP_W-1:0] wp_ext, rp_ext, wp_inc, rp_inc;
  logic [PTR_W-1:0] wp_cur, rp_cur, wp_adv, rp_adv;
  logic             fault, full, empty;

  always_comb begin
    cap_raw = CAP_W'(capacity);
    // clamp to 1..DEPTH
    priority if (cap_raw == '0) begin
      cap_eff = ONE_C;
    end else if (cap_raw > DEPTH_C) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = cap_raw;
    end
  end

  assign fault  = (CAP_W'(rp_r) >= cap_eff) || (CAP_W'(wp_r) >= cap_eff);
  assign wp_cur = fault ? '0 : wp_r;
  assign rp_cur = fault ? '0 : rp_r;

  assign wp_ext = CAP_W'(wp_cur);
  assign rp_ext = CAP_W'(rp_cur);
  assign wp_inc = wp_ext + ONE_C;
  assign rp_inc = rp_ext + ONE_C;
  // wrap at the capacity
  assign wp_adv = (wp_inc >= cap_eff) ? '0 : wp_inc[PTR_W-1:0];
  assign rp_adv = (rp_inc >= cap_eff) ? '0 : rp_inc[PTR_W-1:0];

  assign full  = (wp_adv == rp_cur);
  assign empty = fault || (rp_cur == wp_cur);

  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    res_nxt       = '0;
    res_nxt.valid = accept;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = wp_cur;
    mem_raddr     = rp_cur;
    if (accept) begin
      wp_nxt = wp_cur;
      rp_nxt = rp_cur;
      unique case (func)
        FUNC_WRITE: begin
          if (full) begin
            res_nxt.status = ST_OVERFLOW;
          end else begin
            mem_we = 1'b1;
            wp_nxt = wp_adv;
          end
        end
        FUNC_READ: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            mem_re        = 1'b1;
            res_nxt.rd_ok = 1'b1;
            rp_nxt        = rp_adv;
          end
        end
        default: begin
          res_nxt.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      res_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

@@ hw/rtl/byte_ring_fifo.sv @@
// Byte ring FIFO: capacity register, pointer logic and byte store.
// Each item's result strobes out_valid in the cycle after the transfer: out_valid comes
// from the result register of the pointer logic, read data from the store's read port.
// Throughput: one item per cycle while busy is low; the receiver cannot stall, so results never wait.
// Reset (rst_n low, synchronous): pointers to zero, capacity to 256, busy held
// high for one cycle after reset; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module byte_ring_fifo import brf_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_func,
  input  wire logic [7:0]       in_write_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [7:0]            out_read_data,
  output logic [1:0]            out_status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CAP_N = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W = (CAP_N > CFG_W) ? CAP_N : CFG_W;

  logic [CFG_W-1:0] capacity_r;
  logic             busy_r;
  logic             accept;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_rdata;
  brf_res_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      busy_r     <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        capacity_r <= cfg_data;
      end
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  brf_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W),
    .CAP_W (CAP_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_func),
    .capacity  (capacity_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  brf_store #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_write_data),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid     = res.valid;
  assign out_status    = res.status;
  assign out_read_data = res.rd_ok ? mem_rdata : 8'd0;

  a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without a preceding transfer");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("transfer gave no result");

  a_overflow_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OVERFLOW) |-> $past(in_func == FUNC_WRITE))
    else $error("overflow reported for a read");

  a_data_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_data == 8'd0))
    else $error("read data on a failed item");

endmodule
`default_nettype wire

@@ tb/byte_ring_fifo_tb.sv @@
// Self-checking testbench for the byte ring FIFO: directed and random transfers.
`timescale 1ns / 1ps
module byte_ring_fifo_tb;
  import brf_pkg::*;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned NUM_ITEMS   = 1300;
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } fifo_op_t;

  typedef struct packed {
    logic [7:0] read_data;
    status_t    status;
  } fifo_result_t;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             start         = 1'b0;
  logic             in_func       = FUNC_WRITE;
  logic [7:0]       in_write_data = '0;
  logic             cfg_we        = 1'b0;
  logic [CFG_W-1:0] cfg_data      = CAP_RESET;
  logic             busy;
  logic             out_valid;
  logic [7:0]       out_read_data;
  logic [1:0]       out_status;

  fifo_op_t     op_queue[$];
  fifo_result_t result_queue[$];
  fifo_result_t head_result;
  bit           failed = 1'b0;
  bit           steady = 1'b0;
  int           cycle_count = 0;

  // Shadow copy of the FIFO state
  logic [7:0]       shadow_store [DEPTH];
  int unsigned      shadow_wr  = 0;
  int unsigned      shadow_rd  = 0;
  logic [CFG_W-1:0] shadow_cap = CAP_RESET;

  byte_ring_fifo #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_write_data (in_write_data),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

  always #5 clk = ~clk;

  function automatic int unsigned slots_in_use(logic [CFG_W-1:0] c);
    if (c == 0) return 1;
    if (c > DEPTH) return DEPTH;
    return c;
  endfunction

  function automatic fifo_result_t predict_access(fifo_op_t op);
    int unsigned  cap;
    int unsigned  nxt;
    bit           fault;
    fifo_result_t res;
    cap = slots_in_use(shadow_cap);
    fault = (shadow_rd >= cap) || (shadow_wr >= cap);
    res.read_data = '0;
    res.status = ST_OK;
    if (fault) begin
      shadow_wr = 0;
      shadow_rd = 0;
    end
    if (op.func == FUNC_WRITE) begin
      nxt = (shadow_wr + 1 >= cap) ? 0 : shadow_wr + 1;
      if (nxt == shadow_rd) begin
        res.status = ST_OVERFLOW;
      end else begin
        shadow_store[shadow_wr] = op.data;
        shadow_wr = nxt;
      end
    end else if (fault || shadow_rd == shadow_wr) begin
      res.status = ST_EMPTY;
    end else begin
      res.read_data = shadow_store[shadow_rd];
      shadow_rd = (shadow_rd + 1 >= cap) ? 0 : shadow_rd + 1;
    end
    return res;
  endfunction

  // Driver: present the head of the op queue, predict on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        result_queue.push_back(predict_access(op_queue.pop_front()));
      end
      // hold a pending transfer while the block is busy
      if (!(start && busy)) begin
        if (op_queue.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
          start         <= 1'b1;
          in_func       <= op_queue[0].func;
          in_write_data <= op_queue[0].data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so check each one as it strobes
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (result_queue.size() == 0) begin
        $error("unexpected result: read_data %0h status %0d", out_read_data, out_status);
        failed = 1'b1;
      end else begin
        head_result = result_queue.pop_front();
        if (out_read_data !== head_result.read_data) begin
          $error("read_data: expected %0h, actual %0h", head_result.read_data, out_read_data);
          failed = 1'b1;
        end
        if (out_status !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, out_status);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_op(logic func, logic [7:0] data);
    fifo_op_t op;
    op.func = func;
    op.data = data;
    op_queue.push_back(op);
  endtask

  // Returns on a falling edge once every transfer is done and checked
  task automatic wait_idle();
    do @(negedge clk); while (op_queue.size() != 0 || result_queue.size() != 0);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    shadow_cap = value;
    @(negedge clk);
  endtask

  // Empty the FIFO before a capacity rise, so no read can reach a slot never written
  task automatic drain_fifo();
    int unsigned cap;
    forever begin
      wait_idle();
      cap = slots_in_use(shadow_cap);
      if (shadow_rd >= cap || shadow_wr >= cap) begin
        queue_op(FUNC_READ, 8'($urandom_range(255)));
      end else if (shadow_rd != shadow_wr) begin
        repeat ((shadow_wr + cap - shadow_rd) % cap) queue_op(FUNC_READ, 8'($urandom_range(255)));
      end else begin
        break;
      end
    end
  endtask

  initial begin
    int               issued;
    int               phase;
    int               n_ops;
    int               wr_pct;
    bit               big;
    logic [CFG_W-1:0] new_cap;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset capacity: empty read, edge bytes, drain, empty again
    queue_op(FUNC_READ, 8'hFF);
    queue_op(FUNC_WRITE, 8'h00);
    queue_op(FUNC_WRITE, 8'hFF);
    queue_op(FUNC_WRITE, 8'hA5);
    queue_op(FUNC_WRITE, 8'h5A);
    repeat (5) queue_op(FUNC_READ, 8'($urandom_range(255)));
    wait_idle();

    // lower below the pointers: pointer fault then a write, fill to overflow
    set_capacity(9'd4);
    queue_op(FUNC_WRITE, 8'h11);
    queue_op(FUNC_WRITE, 8'h22);
    queue_op(FUNC_WRITE, 8'h33);
    queue_op(FUNC_WRITE, 8'h44);
    repeat (4) queue_op(FUNC_READ, 8'($urandom_range(255)));
    wait_idle();

    // one slot, then zero: always full and always empty
    set_capacity(9'd1);
    queue_op(FUNC_WRITE, 8'h3C);
    queue_op(FUNC_READ, 8'h00);
    wait_idle();
    set_capacity(9'd0);
    queue_op(FUNC_WRITE, 8'hC3);
    queue_op(FUNC_READ, 8'hFF);
    wait_idle();

    // saturating capacity, then a read that meets a pointer fault
    set_capacity(9'd511);
    queue_op(FUNC_WRITE, 8'h80);
    queue_op(FUNC_WRITE, 8'h01);
    wait_idle();
    set_capacity(9'd2);
    queue_op(FUNC_READ, 8'h00);
    wait_idle();

    issued = 0;
    for (phase = 0; issued < NUM_ITEMS; phase++) begin
      big = (phase == 2);
      case ($urandom_range(9))
        0:       new_cap = 9'd0;
        1:       new_cap = 9'd1;
        2:       new_cap = 9'd2;
        3:       new_cap = 9'd511;
        4:       new_cap = 9'd256;
        5:       new_cap = 9'($urandom_range(511, 257));
        6:       new_cap = 9'($urandom_range(255, 25));
        default: new_cap = 9'($urandom_range(24, 3));
      endcase
      if (big) new_cap = 9'd256;
      if (slots_in_use(new_cap) > slots_in_use(shadow_cap)) drain_fifo();
      set_capacity(new_cap);
      steady = big || (phase % 4 == 1);
      n_ops = big ? 400 : $urandom_range(60, 15);
      case ($urandom_range(2))
        0:       wr_pct = 25;
        1:       wr_pct = 50;
        default: wr_pct = 75;
      endcase
      if (big) wr_pct = 85;
      repeat (n_ops) begin
        queue_op(($urandom_range(99) < wr_pct) ? FUNC_WRITE : FUNC_READ,
                 8'($urandom_range(255)));
      end
      issued += n_ops;
      wait_idle();
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (failed) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

endmodule
